// File: rtl/core/cbta_pkg.sv
// ----------------------------------------------------------------------------
// cbta_pkg : shared types and constants of the clipped blit addresser
// Register indexes, item codes, configuration bundle and pixel-size masks.
// ----------------------------------------------------------------------------
package cbta_pkg;

  // Widest coordinate the configuration bundle carries
  localparam int CoordMaxBits = 16;
  localparam int CfgDataBits  = 16;
  localparam int CfgIndexBits = 3;

  // Configuration register indexes
  typedef enum logic [CfgIndexBits-1:0] {
    REG_BPP          = 3'd0,
    REG_FRAME_PITCH  = 3'd1,
    REG_SRC_PITCH    = 3'd2,
    REG_WIN_LEFT     = 3'd3,
    REG_WIN_TOP      = 3'd4,
    REG_WIN_RIGHT    = 3'd5,
    REG_WIN_BOTTOM   = 3'd6,
    REG_TRANSPARENT  = 3'd7
  } cfg_reg_t;

  // Input action codes and result kind codes
  localparam logic ACT_START   = 1'b0;
  localparam logic ACT_PIXEL   = 1'b1;
  localparam logic KIND_REPORT = 1'b0;
  localparam logic KIND_PIXEL  = 1'b1;

  // Reset values of the configuration registers
  localparam logic [2:0]  RST_BPP          = 3'd4;
  localparam logic [15:0] RST_FRAME_PITCH  = 16'd4096;
  localparam logic [15:0] RST_SRC_PITCH    = 16'd4096;
  localparam logic [15:0] RST_WIN_LEFT     = 16'd0;
  localparam logic [15:0] RST_WIN_TOP      = 16'd0;
  localparam logic [15:0] RST_WIN_RIGHT    = 16'd1023;
  localparam logic [15:0] RST_WIN_BOTTOM   = 16'd767;

  // Configuration bundle; window edges sign-extended to the widest coordinate
  typedef struct packed {
    logic [2:0]                     bpp;
    logic [15:0]                    frame_pitch;
    logic [15:0]                    src_pitch;
    logic signed [CoordMaxBits-1:0] win_left;
    logic signed [CoordMaxBits-1:0] win_top;
    logic signed [CoordMaxBits-1:0] win_right;
    logic signed [CoordMaxBits-1:0] win_bottom;
    logic                           transparent;
  } cfg_t;

  // Bytes of the pixel that are kept; zero for an unsupported size
  function automatic logic [31:0] pixel_mask(input logic [2:0] bpp);
    logic [31:0] m;
    case (bpp)
      3'd1:    m = 32'h0000_00FF;
      3'd2:    m = 32'h0000_FFFF;
      3'd3:    m = 32'h00FF_FFFF;
      3'd4:    m = 32'hFFFF_FFFF;
      default: m = 32'h0000_0000;
    endcase
    return m;
  endfunction

  // Bytes tested for the colour key; three-byte pixels test the low byte only
  function automatic logic [31:0] pixel_test(input logic [2:0] bpp);
    logic [31:0] m;
    case (bpp)
      3'd1:    m = 32'h0000_00FF;
      3'd2:    m = 32'h0000_FFFF;
      3'd3:    m = 32'h0000_00FF;
      3'd4:    m = 32'hFFFF_FFFF;
      default: m = 32'h0000_0000;
    endcase
    return m;
  endfunction

endpackage

// File: rtl/core/cbta_cfg_regs.sv
// ----------------------------------------------------------------------------
// cbta_cfg_regs : configuration register file
// Holds pixel size, pitches, window rectangle and the colour-key mode.
// ----------------------------------------------------------------------------
module cbta_cfg_regs #(
  parameter int COORD_BITS = 13
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [cbta_pkg::CfgIndexBits-1:0]  cfg_index,
  input  logic [cbta_pkg::CfgDataBits-1:0]   cfg_data,
  output cbta_pkg::cfg_t                     cfg
);
  import cbta_pkg::*;

  logic [2:0]            bpp_r;
  logic [15:0]           fpitch_r;
  logic [15:0]           cpitch_r;
  logic [COORD_BITS-1:0] wl_r, wt_r, wr_r, wb_r;
  logic                  trans_r;
  logic                  wr_en;

  // Always ready; a write is registered
  assign cfg_ready = 1'b1;
  assign wr_en     = cfg_valid & cfg_ready;

  // Write the addressed register, keeping the low bits of the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpp_r    <= RST_BPP;
      fpitch_r <= RST_FRAME_PITCH;
      cpitch_r <= RST_SRC_PITCH;
      wl_r     <= RST_WIN_LEFT[COORD_BITS-1:0];
      wt_r     <= RST_WIN_TOP[COORD_BITS-1:0];
      wr_r     <= RST_WIN_RIGHT[COORD_BITS-1:0];
      wb_r     <= RST_WIN_BOTTOM[COORD_BITS-1:0];
      trans_r  <= 1'b0;
    end else if (wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_BPP:          bpp_r    <= cfg_data[2:0];
        REG_FRAME_PITCH:  fpitch_r <= cfg_data[15:0];
        REG_SRC_PITCH:    cpitch_r <= cfg_data[15:0];
        REG_WIN_LEFT:     wl_r     <= cfg_data[COORD_BITS-1:0];
        REG_WIN_TOP:      wt_r     <= cfg_data[COORD_BITS-1:0];
        REG_WIN_RIGHT:    wr_r     <= cfg_data[COORD_BITS-1:0];
        REG_WIN_BOTTOM:   wb_r     <= cfg_data[COORD_BITS-1:0];
        REG_TRANSPARENT:  trans_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Present the bundle with window edges sign-extended
  always_comb begin
    cfg.bpp          = bpp_r;
    cfg.frame_pitch  = fpitch_r;
    cfg.src_pitch    = cpitch_r;
    cfg.win_left     = CoordMaxBits'($signed(wl_r));
    cfg.win_top      = CoordMaxBits'($signed(wt_r));
    cfg.win_right    = CoordMaxBits'($signed(wr_r));
    cfg.win_bottom   = CoordMaxBits'($signed(wb_r));
    cfg.transparent  = trans_r;
  end

endmodule

// File: rtl/core/cbta_clip.sv
// ----------------------------------------------------------------------------
// cbta_clip : clip rectangle clamp and region start offsets
// Clamps the window to the clip rectangle and forms both start offsets.
// ----------------------------------------------------------------------------
module cbta_clip #(
  parameter int COORD_BITS  = 13,
  parameter int OFFSET_BITS = 32
) (
  input  cbta_pkg::cfg_t                 cfg,
  input  logic signed [COORD_BITS-1:0]   clip_left,
  input  logic signed [COORD_BITS-1:0]   clip_top,
  input  logic signed [COORD_BITS-1:0]   clip_right,
  input  logic signed [COORD_BITS-1:0]   clip_bottom,
  output logic [OFFSET_BITS-1:0]         dst_start,
  output logic [OFFSET_BITS-1:0]         src_start,
  output logic [COORD_BITS-1:0]          width,
  output logic [COORD_BITS-1:0]          height
);
  import cbta_pkg::*;

  // One extra bit holds an exclusive edge, two hold a window-relative delta
  localparam int E  = COORD_BITS + 1;
  localparam int D  = COORD_BITS + 2;
  localparam int W  = D + 18;
  localparam int SW = (W > OFFSET_BITS) ? W : OFFSET_BITS;

  logic signed [E-1:0] wl, wt, wr1, wb1, cl, ct, cr1, cb1;
  logic signed [E-1:0] x0, y0, ex, ey, x, y;
  logic [E-1:0]        w_raw, h_raw;
  logic signed [D-1:0] dx, dy, sx, sy;
  logic signed [3:0]   bpp_s;
  logic signed [16:0]  fp_s, cp_s;
  logic signed [D+3:0] pd_x, ps_x;
  logic signed [D+16:0] pd_y, ps_y;
  logic signed [W-1:0] d_sum, s_sum;
  logic signed [SW-1:0] d_ext, s_ext;

  // Edges, right and bottom made exclusive
  assign wl  = E'($signed(cfg.win_left[COORD_BITS-1:0]));
  assign wt  = E'($signed(cfg.win_top[COORD_BITS-1:0]));
  assign wr1 = E'($signed(cfg.win_right[COORD_BITS-1:0])) + E'(1);
  assign wb1 = E'($signed(cfg.win_bottom[COORD_BITS-1:0])) + E'(1);
  assign cl  = E'(clip_left);
  assign ct  = E'(clip_top);
  assign cr1 = E'(clip_right) + E'(1);
  assign cb1 = E'(clip_bottom) + E'(1);

  // Clamp, then collapse an inverted region onto its end edge
  always_comb begin
    x0 = (wl < cl) ? cl : wl;
    y0 = (wt < ct) ? ct : wt;
    ex = (wr1 > cr1) ? cr1 : wr1;
    ey = (wb1 > cb1) ? cb1 : wb1;
    x  = (x0 > ex) ? ex : x0;
    y  = (y0 > ey) ? ey : y0;
  end

  // Size is never negative here; saturate the one value past the range
  assign w_raw  = ex - x;
  assign h_raw  = ey - y;
  assign width  = w_raw[COORD_BITS] ? '1 : w_raw[COORD_BITS-1:0];
  assign height = h_raw[COORD_BITS] ? '1 : h_raw[COORD_BITS-1:0];

  // Start offsets: column times pixel size plus row times pitch
  assign bpp_s = $signed({1'b0, cfg.bpp});
  assign fp_s  = $signed({1'b0, cfg.frame_pitch});
  assign cp_s  = $signed({1'b0, cfg.src_pitch});
  assign dx    = D'(x);
  assign dy    = D'(y);
  assign sx    = D'(x) - D'(wl);
  assign sy    = D'(y) - D'(wt);
  assign pd_x  = (D+4)'(dx) * (D+4)'(bpp_s);
  assign pd_y  = (D+17)'(dy) * (D+17)'(fp_s);
  assign ps_x  = (D+4)'(sx) * (D+4)'(bpp_s);
  assign ps_y  = (D+17)'(sy) * (D+17)'(cp_s);
  assign d_sum = W'(pd_x) + W'(pd_y);
  assign s_sum = W'(ps_x) + W'(ps_y);

  // Wrap to the offset width
  assign d_ext     = SW'(d_sum);
  assign s_ext     = SW'(s_sum);
  assign dst_start = d_ext[OFFSET_BITS-1:0];
  assign src_start = s_ext[OFFSET_BITS-1:0];

endmodule

// File: rtl/core/clipped_transparent_blit_addresser.sv
// ----------------------------------------------------------------------------
// clipped_transparent_blit_addresser : clipped colour-keyed blit addressing
// Clamps the window to a clip rectangle and walks it pixel by pixel.
// ----------------------------------------------------------------------------
// Usage:
//   Write the window rectangle, pitches, pixel size and key mode on the cfg_
//   channel while the block is idle. Send a start item (in_tuser = 0) with a
//   clip rectangle; one region report comes back with the clipped start
//   offsets and size, tlast set when the region is empty. Then send the
//   source pixels of the region in raster order (in_tuser = 1); each gives
//   one result with both byte offsets, the masked pixel and a write enable,
//   tlast on the final pixel. A pixel with no region pending comes back as
//   a stray result that writes nothing. A new start abandons a region.
//   Every item gives exactly one result; each item waits in the input
//   register and its result in the output register. One item is taken every
//   cycle while out_tready does not stall; the rate is set by the single
//   register stage of region state that each pixel steps.
//   An input register and an output register part the two sides, so the
//   block keeps accepting while a result waits; a stall of out_tready
//   holds the result and backs up into in_tready after one item.
//   Reset empties both registers, clears the region state and returns the
//   configuration to its reset values.
// ----------------------------------------------------------------------------
module clipped_transparent_blit_addresser #(
  parameter int COORD_BITS  = 13,
  parameter int OFFSET_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input items
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // tdata: clip_left, clip_top, clip_right, clip_bottom, pixel_in, zero pad
  input  logic [((4*COORD_BITS+32+7)/8)*8-1:0] in_tdata,
  // tuser: action
  input  logic                              in_tuser,
  // Result items
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // tdata: dst_offset, src_offset, region_width, region_height, pixel_out,
  //        write_enable, stray, zero pad
  output logic [((2*OFFSET_BITS+2*COORD_BITS+34+7)/8)*8-1:0] out_tdata,
  // tuser: kind
  output logic                              out_tuser,
  output logic                              out_tlast,
  // Configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [cbta_pkg::CfgIndexBits-1:0] cfg_index,
  input  logic [cbta_pkg::CfgDataBits-1:0]  cfg_data
);
  import cbta_pkg::*;

  localparam int C     = COORD_BITS;
  localparam int O     = OFFSET_BITS;
  localparam int OUT_W = ((2*O+2*C+34+7)/8)*8;
  localparam int SP    = ((C+3) > O) ? (C+3) : O;

  cfg_t cfg;

  // Input register
  logic                in_v_r, in_v_nxt;
  logic                act_r;
  logic signed [C-1:0] cl_r, ct_r, cr_r, cb_r;
  logic [31:0]         px_r;
  logic                in_accept, advance;

  // Region state
  logic         active_r, active_nxt;
  logic [C-1:0] cc_r, cc_nxt, rc_r, rc_nxt;
  logic [C-1:0] cols_r, cols_nxt, rows_r, rows_nxt;
  logic [O-1:0] dbase_r, dbase_nxt, sbase_r, sbase_nxt;

  // Result
  logic         out_v_r, out_v_nxt;
  logic         kind_r, kind_nxt, last_r, last_nxt, we_r, we_nxt, stray_r, stray_nxt;
  logic [O-1:0] dst_r, dst_nxt, src_r, src_nxt;
  logic [C-1:0] w_r, w_nxt, h_r, h_nxt;
  logic [31:0]  pxo_r, pxo_nxt;

  // Start and pixel arithmetic
  logic [O-1:0]  dst_start, src_start;
  logic [C-1:0]  reg_w, reg_h;
  logic          region_ok;
  logic [C+2:0]  step;
  logic [SP-1:0] step_x;
  logic [O-1:0]  step_o;
  logic [C-1:0]  cc_inc, rc_inc;
  logic [31:0]   mask, test;

  cbta_cfg_regs #(.COORD_BITS(C)) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  cbta_clip #(.COORD_BITS(C), .OFFSET_BITS(O)) u_clip (
    .cfg         (cfg),
    .clip_left   (cl_r),
    .clip_top    (ct_r),
    .clip_right  (cr_r),
    .clip_bottom (cb_r),
    .dst_start   (dst_start),
    .src_start   (src_start),
    .width       (reg_w),
    .height      (reg_h)
  );

  // Handshake: advance when the output register is free or being emptied
  assign advance   = in_v_r & (~out_v_r | out_tready);
  assign in_tready = ~in_v_r | advance;
  assign in_accept = in_tvalid & in_tready;
  assign in_v_nxt  = in_accept ? 1'b1 : (advance ? 1'b0 : in_v_r);
  assign out_v_nxt = advance ? 1'b1 : (out_tready ? 1'b0 : out_v_r);

  // Hold the accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= in_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      act_r <= in_tuser;
      cl_r  <= $signed(in_tdata[C-1:0]);
      ct_r  <= $signed(in_tdata[2*C-1:C]);
      cr_r  <= $signed(in_tdata[3*C-1:2*C]);
      cb_r  <= $signed(in_tdata[4*C-1:3*C]);
      px_r  <= in_tdata[4*C+31:4*C];
    end
  end

  // Pixel step within the current row
  assign step      = (C+3)'(cc_r) * (C+3)'(cfg.bpp);
  assign step_x    = SP'(step);
  assign step_o    = step_x[O-1:0];
  assign cc_inc    = cc_r + C'(1);
  assign rc_inc    = rc_r + C'(1);
  assign mask      = pixel_mask(cfg.bpp);
  assign test      = pixel_test(cfg.bpp);
  assign region_ok = (|reg_w) & (|reg_h);

  // Form the result and the next region state
  always_comb begin
    active_nxt = active_r;
    cc_nxt     = cc_r;
    rc_nxt     = rc_r;
    cols_nxt   = cols_r;
    rows_nxt   = rows_r;
    dbase_nxt  = dbase_r;
    sbase_nxt  = sbase_r;
    kind_nxt   = KIND_PIXEL;
    dst_nxt    = '0;
    src_nxt    = '0;
    w_nxt      = '0;
    h_nxt      = '0;
    pxo_nxt    = '0;
    we_nxt     = 1'b0;
    last_nxt   = 1'b0;
    stray_nxt  = 1'b0;
    if (act_r == ACT_START) begin
      // Latch the clipped region and report it
      kind_nxt   = KIND_REPORT;
      dst_nxt    = dst_start;
      src_nxt    = src_start;
      w_nxt      = reg_w;
      h_nxt      = reg_h;
      last_nxt   = ~region_ok;
      active_nxt = region_ok;
      cols_nxt   = reg_w;
      rows_nxt   = reg_h;
      cc_nxt     = '0;
      rc_nxt     = '0;
      dbase_nxt  = dst_start;
      sbase_nxt  = src_start;
    end else if (!active_r) begin
      stray_nxt = 1'b1;
    end else begin
      // Address the pixel, apply the colour key, then step the walk
      dst_nxt = dbase_r + step_o;
      src_nxt = sbase_r + step_o;
      pxo_nxt = px_r & mask;
      we_nxt  = (|mask) & (~cfg.transparent | (|(px_r & test)));
      if (cc_inc >= cols_r) begin
        cc_nxt    = '0;
        rc_nxt    = rc_inc;
        dbase_nxt = dbase_r + O'(cfg.frame_pitch);
        sbase_nxt = sbase_r + O'(cfg.src_pitch);
        if (rc_inc >= rows_r) begin
          last_nxt   = 1'b1;
          active_nxt = 1'b0;
        end
      end else begin
        cc_nxt = cc_inc;
      end
    end
  end

  // Advance region state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      cc_r     <= '0;
      rc_r     <= '0;
      cols_r   <= '0;
      rows_r   <= '0;
      dbase_r  <= '0;
      sbase_r  <= '0;
    end else if (advance) begin
      active_r <= active_nxt;
      cc_r     <= cc_nxt;
      rc_r     <= rc_nxt;
      cols_r   <= cols_nxt;
      rows_r   <= rows_nxt;
      dbase_r  <= dbase_nxt;
      sbase_r  <= sbase_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      kind_r  <= kind_nxt;
      dst_r   <= dst_nxt;
      src_r   <= src_nxt;
      w_r     <= w_nxt;
      h_r     <= h_nxt;
      pxo_r   <= pxo_nxt;
      we_r    <= we_nxt;
      last_r  <= last_nxt;
      stray_r <= stray_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = kind_r;
  assign out_tlast  = last_r;
  assign out_tdata  = OUT_W'({stray_r, we_r, pxo_r, h_r, w_r, src_r, dst_r});

endmodule

// File: rtl/core/cbta_checker.sv
// ----------------------------------------------------------------------------
// cbta_checker : port-level checks of the blit addresser
// Watches the result channel and the reset behaviour.
// ----------------------------------------------------------------------------
module cbta_checker #(
  parameter int COORD_BITS  = 13,
  parameter int OFFSET_BITS = 32
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [((2*OFFSET_BITS+2*COORD_BITS+34+7)/8)*8-1:0] out_tdata,
  input logic                              out_tuser,
  input logic                              out_tlast
);
  import cbta_pkg::*;

  localparam int W_LO  = 2*OFFSET_BITS;
  localparam int PX_LO = 2*OFFSET_BITS + 2*COORD_BITS;
  localparam int WE    = PX_LO + 32;
  localparam int STRAY = WE + 1;

  // A stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

  // A stray pixel is a pixel result that writes nothing and ends nothing
  a_stray: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[STRAY] |->
      out_tuser == KIND_PIXEL && !out_tdata[WE] && !out_tlast)
    else $error("malformed stray result");

  // A region report carries no pixel and no write
  a_report: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_REPORT |->
      !out_tdata[WE] && out_tdata[PX_LO+31:PX_LO] == 32'd0)
    else $error("region report carries a pixel");

  // An empty region report closes the run
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_REPORT &&
      out_tdata[W_LO+COORD_BITS-1:W_LO] == '0 |-> out_tlast)
    else $error("empty region not flagged last");

  // Reset empties the output register
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind clipped_transparent_blit_addresser cbta_checker #(
  .COORD_BITS  (COORD_BITS),
  .OFFSET_BITS (OFFSET_BITS)
) u_cbta_checker (.*);
